FILE: hdl/sketch_fingerprint_accumulator_unit_macros.svh
// Assertion macros shared by the fingerprint accumulator RTL.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef SKETCH_FINGERPRINT_ACCUMULATOR_UNIT_MACROS_SVH
`define SKETCH_FINGERPRINT_ACCUMULATOR_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SFA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication outside reset.
`define SFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/sfa_pkg.sv
// Shared types, constants and modular arithmetic helpers for the fingerprint accumulator.
// No dependencies.
`timescale 1ns / 1ps

package sfa_pkg;

  localparam int unsigned ITEM_BITS_DEF = 32;
  localparam int unsigned ITEM_W       = 32;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // p = 2^32 - 5
  localparam logic [DATA_W-1:0] FP_PRIME = 32'hFFFF_FFFB;

  localparam logic [1:0] OP_LEVEL   = 2'd0;
  localparam logic [1:0] OP_CHECK   = 2'd1;
  localparam logic [1:0] OP_COMPARE = 2'd2;

  typedef enum logic [1:0] {
    KIND_LEVEL,
    KIND_CHECK,
    KIND_COMPARE,
    KIND_NOP
  } kind_t;

  localparam int unsigned KIND_W = 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POW,
    S_PWAIT,
    S_TWAIT,
    S_ACC,
    S_DONE
  } state_t;

  // Fold a 64-bit product mod p using 2^32 == 5 (mod p).
  function automatic logic [DATA_W-1:0] mod_reduce(input logic [63:0] x);
    logic [34:0] t;
    logic [32:0] u;
    logic [32:0] v;
    t = {3'b000, x[63:32]} + {1'b0, x[63:32], 2'b00} + {3'b000, x[31:0]};
    u = {1'b0, t[31:0]} + {28'd0, t[34:32], 2'b00} + {30'd0, t[34:32]};
    v = u - {1'b0, FP_PRIME};
    if (u >= {1'b0, FP_PRIME}) begin
      return v[31:0];
    end
    return u[31:0];
  endfunction

  // Sum of two residues mod p.
  function automatic logic [DATA_W-1:0] add_mod(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    logic [32:0] s;
    logic [32:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, FP_PRIME};
    if (s >= {1'b0, FP_PRIME}) begin
      return d[31:0];
    end
    return s[31:0];
  endfunction

endpackage

FILE: hdl/sfa_front.sv
// Front end: input handshake and item classification into queue entries.
// Depends on sfa_pkg.
`timescale 1ns / 1ps

module sfa_front #(
  parameter int unsigned ITEM_BITS = sfa_pkg::ITEM_BITS_DEF
) (
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            opcode,
  input  logic [sfa_pkg::ITEM_W-1:0]            item_id,
  input  logic signed [sfa_pkg::DATA_W-1:0]     delta,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [sfa_pkg::KIND_W + ((ITEM_BITS < sfa_pkg::ITEM_W) ? ITEM_BITS :
                sfa_pkg::ITEM_W) + sfa_pkg::DATA_W - 1:0] q_entry
);
  import sfa_pkg::*;

  localparam int unsigned EXP_BITS = (ITEM_BITS < ITEM_W) ? ITEM_BITS : ITEM_W;

  kind_t             kind;
  logic [DATA_W-1:0] delta_u;
  logic [DATA_W-1:0] delta_mod;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign delta_u  = $unsigned(delta);

  // negative v maps to p - (2^32 - v), which is v - 5 in 32 bits
  assign delta_mod = delta_u[DATA_W-1] ? (delta_u - 32'd5) : delta_u;

  always_comb begin
    case (opcode)
      OP_LEVEL:   kind = (delta_u == '0) ? KIND_NOP : KIND_LEVEL;
      OP_CHECK:   kind = KIND_CHECK;
      OP_COMPARE: kind = KIND_COMPARE;
      default:    kind = KIND_NOP;
    endcase
  end

  assign q_entry = {kind, item_id[EXP_BITS-1:0], delta_mod};

endmodule

FILE: hdl/sfa_queue.sv
// Small FIFO that decouples the classifier from the exponentiation sequencer.
// Depends on sfa_pkg for the default depth.
`timescale 1ns / 1ps

module sfa_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = sfa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/sfa_mulmod.sv
// Modular multiplier mod p: registered 32x32 product, combinational fold.
// Depends on sfa_pkg (mod_reduce).
`timescale 1ns / 1ps

module sfa_mulmod (
  input  logic                         clk,
  input  logic                         en,
  input  logic [sfa_pkg::DATA_W-1:0]   a,
  input  logic [sfa_pkg::DATA_W-1:0]   b,
  output logic [sfa_pkg::DATA_W-1:0]   res
);
  import sfa_pkg::*;

  logic [2*DATA_W-1:0] prod_q;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_q <= {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
    end
  end

  assign res = mod_reduce(prod_q);

endmodule

FILE: hdl/sfa_back.sv
// Back end: square-and-multiply sequencer, accumulators, base register, output register.
// Depends on sfa_pkg, sfa_mulmod and the assertion macro header.
`timescale 1ns / 1ps
`include "sketch_fingerprint_accumulator_unit_macros.svh"

module sfa_back #(
  parameter int unsigned ITEM_BITS = sfa_pkg::ITEM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [sfa_pkg::DATA_W-1:0]    cfg_data,
  input  logic                          q_valid,
  input  logic [sfa_pkg::KIND_W + ((ITEM_BITS < sfa_pkg::ITEM_W) ? ITEM_BITS :
                sfa_pkg::ITEM_W) + sfa_pkg::DATA_W - 1:0] q_entry,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfa_pkg::DATA_W-1:0]    level_fingerprint,
  output logic [sfa_pkg::DATA_W-1:0]    check_fingerprint,
  output logic                          match
);
  import sfa_pkg::*;

  localparam int unsigned EXP_BITS = (ITEM_BITS < ITEM_W) ? ITEM_BITS : ITEM_W;
  localparam int unsigned ENTRY_W  = KIND_W + EXP_BITS + DATA_W;

  state_t              state;
  state_t              state_next;
  kind_t               kind_q;
  logic [EXP_BITS-1:0] exp_q;
  logic [DATA_W-1:0]   dmod_q;
  logic [DATA_W-1:0]   r_q;
  logic [DATA_W-1:0]   b_q;
  logic [DATA_W-1:0]   term_q;
  logic [DATA_W-1:0]   base_q;
  logic [DATA_W-1:0]   level_sum;
  logic [DATA_W-1:0]   check_sum;

  logic                issue;
  logic                out_load;
  logic                out_free;
  logic [DATA_W-1:0]   mul_a_x;
  logic [DATA_W-1:0]   mul_a_y;
  logic [DATA_W-1:0]   mul_a_res;
  logic [DATA_W-1:0]   mul_b_res;
  logic [DATA_W-1:0]   cfg_red;

  assign out_free = !out_valid || out_ready;
  assign cfg_red  = (cfg_data >= FP_PRIME) ? (cfg_data - FP_PRIME) : cfg_data;

  // unit A does r*b per bit, then delta*power at the end; unit B squares
  assign mul_a_x = (exp_q == '0) ? dmod_q : r_q;
  assign mul_a_y = (exp_q == '0) ? r_q : b_q;

  sfa_mulmod u_mul_a (
    .clk (clk),
    .en  (issue),
    .a   (mul_a_x),
    .b   (mul_a_y),
    .res (mul_a_res)
  );

  sfa_mulmod u_mul_b (
    .clk (clk),
    .en  (issue),
    .a   (b_q),
    .b   (b_q),
    .res (mul_b_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          if ((kind_t'(q_entry[ENTRY_W-1 -: KIND_W]) == KIND_LEVEL) ||
              (kind_t'(q_entry[ENTRY_W-1 -: KIND_W]) == KIND_CHECK)) begin
            state_next = S_POW;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_POW:   state_next = (exp_q == '0) ? S_TWAIT : S_PWAIT;
      S_PWAIT: state_next = S_POW;
      S_TWAIT: state_next = S_ACC;
      S_ACC:   state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state == S_IDLE) && q_valid;
    issue    = (state == S_POW);
    out_load = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers of the current item
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_pop) begin
          kind_q <= kind_t'(q_entry[ENTRY_W-1 -: KIND_W]);
          exp_q  <= q_entry[DATA_W +: EXP_BITS];
          dmod_q <= q_entry[DATA_W-1:0];
          r_q    <= {{(DATA_W-1){1'b0}}, 1'b1};
          b_q    <= base_q;
        end
      end
      S_PWAIT: begin
        if (exp_q[0]) begin
          r_q <= mul_a_res;
        end
        b_q   <= mul_b_res;
        exp_q <= exp_q >> 1;
      end
      S_TWAIT: term_q <= mul_a_res;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_q    <= 32'd2;
      level_sum <= '0;
      check_sum <= '0;
    end else begin
      if (cfg_valid) begin
        base_q <= cfg_red;
      end
      if (state == S_ACC) begin
        if (kind_q == KIND_LEVEL) begin
          level_sum <= add_mod(level_sum, term_q);
        end else begin
          check_sum <= add_mod(check_sum, term_q);
        end
      end else if (out_load && (kind_q == KIND_COMPARE)) begin
        check_sum <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      level_fingerprint <= level_sum;
      check_fingerprint <= check_sum;
      match             <= (kind_q == KIND_COMPARE) && (check_sum == level_sum);
    end
  end

  `SFA_ASSERT_ALWAYS(a_level_reduced, level_sum < FP_PRIME, "level sum not reduced mod p")
  `SFA_ASSERT_ALWAYS(a_check_reduced, check_sum < FP_PRIME, "check sum not reduced mod p")
  `SFA_ASSERT_IMPL(a_match_equal, out_valid && match, level_fingerprint == check_fingerprint, "match set on unequal sums")
  `SFA_ASSERT_IMPL(a_pop_idle, q_pop, state == S_IDLE, "queue popped while busy")

endmodule

FILE: hdl/sketch_fingerprint_accumulator_unit.sv
// Top level of the polynomial fingerprint accumulator (mod 4294967291).
// Depends on sfa_pkg, sfa_front, sfa_queue, sfa_mulmod and sfa_back.
//
// Input beat (in_valid/in_ready): opcode, item_id, delta. Output beat
// (out_valid/out_ready): level_fingerprint, check_fingerprint, match; exactly one
// per input beat, in order. Config (cfg_valid/cfg_ready, always ready): cfg_data
// sets the fingerprint base, reduced mod p on write. Write only while idle.
// Sequence: a level update with nonzero delta or a check add runs square-and-multiply
//   on two modular multipliers: after the pop, states S_POW and S_PWAIT repeat for each
//   exponent bit up to and including the highest set bit of item_id, followed by the
//   final multiply, term capture, accumulate and output load. Compare, unused opcode
//   and zero-delta level beats go from the pop straight to the output load. One item
//   is in the sequencer at a time.
// Stalls: a two-entry queue between classifier and sequencer takes up to two more
//   beats while the sequencer works or the receiver stalls; then in_ready drops.
//   The result register holds its beat until out_ready.
// Reset: rst (synchronous, active high) clears both sums and the queue and sets
//   the base to 2.
`timescale 1ns / 1ps

module sketch_fingerprint_accumulator_unit #(
  parameter int unsigned ITEM_BITS = sfa_pkg::ITEM_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sfa_pkg::DATA_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         opcode,
  input  logic [sfa_pkg::ITEM_W-1:0]         item_id,
  input  logic signed [sfa_pkg::DATA_W-1:0]  delta,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sfa_pkg::DATA_W-1:0]         level_fingerprint,
  output logic [sfa_pkg::DATA_W-1:0]         check_fingerprint,
  output logic                               match
);
  import sfa_pkg::*;

  // exponent bits beyond the item_id port are zero and do not change the power
  localparam int unsigned EXP_BITS = (ITEM_BITS < ITEM_W) ? ITEM_BITS : ITEM_W;
  localparam int unsigned ENTRY_W  = KIND_W + EXP_BITS + DATA_W;

  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_valid;
  logic [ENTRY_W-1:0] q_in;
  logic [ENTRY_W-1:0] q_out;

  // config is written straight into the base register, so never back-pressured
  assign cfg_ready = 1'b1;

  sfa_front #(
    .ITEM_BITS (ITEM_BITS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .item_id  (item_id),
    .delta    (delta),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  sfa_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  sfa_back #(
    .ITEM_BITS (ITEM_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .q_valid           (q_valid),
    .q_entry           (q_out),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .level_fingerprint (level_fingerprint),
    .check_fingerprint (check_fingerprint),
    .match             (match)
  );

endmodule
